FILE: rtl/shrm_pkg.sv
package shrm_pkg;

	// configuration port
	localparam int CFG_DATA_BITS = 64;
	localparam int CFG_IDX_BITS  = 3;

	localparam logic [CFG_IDX_BITS-1:0] REG_LEFT_ROW_A  = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_LEFT_ROW_B  = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_LEFT_ROW_C  = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_RIGHT_ROW_A = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_RIGHT_ROW_B = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] REG_RIGHT_ROW_C = 3'd5;
	localparam logic [CFG_IDX_BITS-1:0] REG_LEFT_SIZE   = 3'd6;
	localparam logic [CFG_IDX_BITS-1:0] REG_RIGHT_SIZE  = 3'd7;

	// row register layout
	localparam int SHIFT_LSB  = 60;
	localparam int SHIFT_BITS = 4;

	// two cameras, three homography rows each
	localparam int NUM_CAM      = 2;
	localparam int ROWS_PER_CAM = 3;
	localparam int NROWS        = NUM_CAM * ROWS_PER_CAM;
	localparam int NLANE        = 2 * NUM_CAM;

	// front to back queue
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_BITS   = 2;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

endpackage

FILE: rtl/shrm_pix_if.sv
interface shrm_pix_if #(parameter int COORD_BITS = 12);
	logic                  valid;
	logic                  ready;
	logic [COORD_BITS-1:0] out_col;
	logic [COORD_BITS-1:0] out_row;

	modport source (output valid, output out_col, output out_row, input ready);
	modport sink (input valid, input out_col, input out_row, output ready);
endinterface

FILE: rtl/shrm_res_if.sv
interface shrm_res_if #(parameter int COORD_BITS = 12);
	logic                    valid;
	logic                    ready;
	logic [COORD_BITS-1:0]   left_src_x;
	logic [COORD_BITS-1:0]   left_src_y;
	logic                    left_hit;
	logic [2*COORD_BITS-1:0] left_src_index;
	logic [COORD_BITS-1:0]   right_src_x;
	logic [COORD_BITS-1:0]   right_src_y;
	logic                    right_hit;
	logic [2*COORD_BITS-1:0] right_src_index;

	modport source (output valid, output left_src_x, output left_src_y, output left_hit,
		output left_src_index, output right_src_x, output right_src_y, output right_hit,
		output right_src_index, input ready);
	modport sink (input valid, input left_src_x, input left_src_y, input left_hit,
		input left_src_index, input right_src_x, input right_src_y, input right_hit,
		input right_src_index, output ready);
endinterface

FILE: rtl/shrm_cfg_if.sv
interface shrm_cfg_if import shrm_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [CFG_IDX_BITS-1:0]  index;
	logic [CFG_DATA_BITS-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

FILE: rtl/shrm_front.sv
module shrm_front import shrm_pkg::*; #(
	parameter int COORD_BITS = 12,
	parameter int MANTISSA_BITS = 20,
	localparam int PW = MANTISSA_BITS + COORD_BITS + 1,
	localparam int SW = MANTISSA_BITS + COORD_BITS + 2
) (
	input  logic                                clk,
	input  logic                                arst_n,
	shrm_pix_if.sink                            pix,
	input  logic [NROWS-1:0][CFG_DATA_BITS-1:0] rows,
	input  qstat_t                              qstat,
	output logic                                push,
	output logic [NROWS-1:0][SW-1:0]            sums
);

	logic adv;
	logic v_s1, v_s2;
	logic signed [COORD_BITS:0] col_sx, row_sx;
	logic signed [PW-1:0] prod_a_s1 [NROWS];
	logic signed [PW-1:0] prod_b_s1 [NROWS];
	logic signed [SW-1:0] sum_s2 [NROWS];

	// stall only when the last stage holds a sum the queue cannot take
	assign adv       = !v_s2 || !qstat.full;
	assign pix.ready = adv;
	assign push      = v_s2 && !qstat.full;
	assign col_sx    = $signed({1'b0, pix.out_col});
	assign row_sx    = $signed({1'b0, pix.out_row});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= pix.valid;
			v_s2 <= v_s1;
		end
	end

	for (genvar r = 0; r < NROWS; r++) begin : g_row
		logic signed [MANTISSA_BITS-1:0] m_a, m_b, m_c;
		assign m_a = $signed(rows[r][0 +: MANTISSA_BITS]);
		assign m_b = $signed(rows[r][MANTISSA_BITS +: MANTISSA_BITS]);
		assign m_c = $signed(rows[r][2*MANTISSA_BITS +: MANTISSA_BITS]);

		always_ff @(posedge clk) begin
			if (adv) begin
				prod_a_s1[r] <= m_a * col_sx;
				prod_b_s1[r] <= m_b * row_sx;
				sum_s2[r]    <= SW'(prod_a_s1[r]) + SW'(prod_b_s1[r]) + SW'(m_c);
			end
		end
		assign sums[r] = sum_s2[r];
	end

endmodule

FILE: rtl/shrm_queue.sv
module shrm_queue import shrm_pkg::*; #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] push_data,
	input  logic         pop,
	output logic [W-1:0] pop_data,
	output qstat_t       qstat
);

	logic [W-1:0]         mem_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
	logic [QPTR_BITS:0]   count_q;

	assign qstat.full  = (count_q == (QPTR_BITS+1)'(QUEUE_DEPTH));
	assign qstat.empty = (count_q == '0);
	assign pop_data    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			priority if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		qstat.full && !pop |-> !push)
		else $error("push into full queue");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !qstat.empty)
		else $error("pop from empty queue");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (QPTR_BITS+1)'(QUEUE_DEPTH))
		else $error("queue count beyond depth");

endmodule

FILE: rtl/shrm_back.sv
module shrm_back import shrm_pkg::*; #(
	parameter int COORD_BITS = 12,
	parameter int MANTISSA_BITS = 20,
	localparam int SW = MANTISSA_BITS + COORD_BITS + 2,
	localparam int NW = SW + (1 << SHIFT_BITS) + 1,
	localparam int DW = NW + COORD_BITS + 1,
	localparam int LAST = COORD_BITS + 1
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic [NROWS-1:0][CFG_DATA_BITS-1:0]   rows,
	input  logic [NUM_CAM-1:0][2*COORD_BITS-1:0]  sizes,
	input  qstat_t                                qstat,
	input  logic [NROWS-1:0][SW-1:0]              sums,
	output logic                                  pop,
	shrm_res_if.source                            res
);

	localparam int C = COORD_BITS;

	logic adv;
	logic [LAST:0]      vld_q;
	logic [NW-1:0]      rem_q [0:LAST][NLANE];
	logic [NW-1:0]      den_q [0:LAST][NLANE];
	logic [C:0]         quo_q [0:LAST][NLANE];
	logic [NLANE-1:0]   neg_q [0:LAST];
	logic [NUM_CAM-1:0] zero_q [0:LAST];
	logic               res_valid_q;
	logic [C-1:0]       x_q [NUM_CAM];
	logic [C-1:0]       y_q [NUM_CAM];
	logic               hit_q [NUM_CAM];
	logic [2*C-1:0]     idx_q [NUM_CAM];

	assign adv = !res_valid_q || res.ready;
	assign pop = adv && !qstat.empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q       <= '0;
			res_valid_q <= 1'b0;
		end else if (adv) begin
			vld_q       <= {vld_q[LAST-1:0], !qstat.empty};
			res_valid_q <= vld_q[LAST];
		end
	end

	// entry stage: magnitudes, signs and the rounding numerator
	for (genvar l = 0; l < NLANE; l++) begin : g_entry
		localparam int CAM = l / 2;
		localparam int RN  = CAM * ROWS_PER_CAM + (l % 2);
		localparam int RD  = CAM * ROWS_PER_CAM + 2;
		logic signed [SW-1:0] n_v, d_v;
		logic [SW-1:0] n_mag, d_mag;
		logic [SHIFT_BITS-1:0] sn, sd;
		logic [NW-1:0] num2, den1;
		assign n_v   = $signed(sums[RN]);
		assign d_v   = $signed(sums[RD]);
		assign n_mag = n_v[SW-1] ? SW'(-n_v) : SW'(n_v);
		assign d_mag = d_v[SW-1] ? SW'(-d_v) : SW'(d_v);
		assign sn    = rows[RN][SHIFT_LSB +: SHIFT_BITS];
		assign sd    = rows[RD][SHIFT_LSB +: SHIFT_BITS];
		assign num2  = (NW'(n_mag) << sd) << 1;
		assign den1  = NW'(d_mag) << sn;

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_q[0][l] <= num2 + den1;
				den_q[0][l] <= den1 << 1;
				quo_q[0][l] <= '0;
				neg_q[0][l] <= n_v[SW-1] ^ d_v[SW-1];
			end
		end
	end

	for (genvar c = 0; c < NUM_CAM; c++) begin : g_zero
		always_ff @(posedge clk) begin
			if (adv) begin
				zero_q[0][c] <= (sums[c*ROWS_PER_CAM+2] == '0);
			end
		end
	end

	// restoring divider, one quotient bit per stage; the first bit is overflow
	for (genvar j = 1; j <= LAST; j++) begin : g_div
		localparam int P = LAST - j;
		always_ff @(posedge clk) begin
			if (adv) begin
				neg_q[j]  <= neg_q[j-1];
				zero_q[j] <= zero_q[j-1];
			end
		end
		for (genvar l = 0; l < NLANE; l++) begin : g_lane
			logic [DW-1:0] trial;
			logic ge;
			assign trial = DW'(den_q[j-1][l]) << P;
			assign ge    = DW'(rem_q[j-1][l]) >= trial;
			always_ff @(posedge clk) begin
				if (adv) begin
					rem_q[j][l] <= ge ? NW'(DW'(rem_q[j-1][l]) - trial) : rem_q[j-1][l];
					den_q[j][l] <= den_q[j-1][l];
					quo_q[j][l] <= {quo_q[j-1][l][C-1:0], ge};
				end
			end
		end
	end

	// bounds check and linear index
	for (genvar c = 0; c < NUM_CAM; c++) begin : g_out
		logic [C-1:0] x, y, w, h;
		logic ovf, below, hit;
		assign x     = quo_q[LAST][2*c][C-1:0];
		assign y     = quo_q[LAST][2*c+1][C-1:0];
		assign w     = sizes[c][C-1:0];
		assign h     = sizes[c][2*C-1:C];
		assign ovf   = quo_q[LAST][2*c][C] || quo_q[LAST][2*c+1][C];
		assign below = (neg_q[LAST][2*c] && x != '0) || (neg_q[LAST][2*c+1] && y != '0);
		assign hit   = !zero_q[LAST][c] && !ovf && !below && (x < w) && (y < h);

		always_ff @(posedge clk) begin
			if (adv) begin
				hit_q[c] <= hit;
				x_q[c]   <= hit ? x : '0;
				y_q[c]   <= hit ? y : '0;
				idx_q[c] <= hit ? (2*C)'(y) * (2*C)'(w) + (2*C)'(x) : '0;
			end
		end
	end

	assign res.valid           = res_valid_q;
	assign res.left_src_x      = x_q[0];
	assign res.left_src_y      = y_q[0];
	assign res.left_hit        = hit_q[0];
	assign res.left_src_index  = idx_q[0];
	assign res.right_src_x     = x_q[1];
	assign res.right_src_y     = y_q[1];
	assign res.right_hit       = hit_q[1];
	assign res.right_src_index = idx_q[1];

	a_left_in_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && hit_q[0] |-> x_q[0] < sizes[0][C-1:0] && y_q[0] < sizes[0][2*C-1:C])
		else $error("left hit outside image");
	a_right_in_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && hit_q[1] |-> x_q[1] < sizes[1][C-1:0] && y_q[1] < sizes[1][2*C-1:C])
		else $error("right hit outside image");
	a_zero_den_miss: assert property (@(posedge clk) disable iff (!arst_n)
		adv && vld_q[LAST] && zero_q[LAST][0] |=> !hit_q[0])
		else $error("zero denominator gave a left hit");

endmodule

FILE: rtl/stereo_homography_remap_unit.sv
// throughput: one pixel per cycle while res is ready, set by the fully pipelined restoring dividers
// front (two multiply/sum stages) and back (divider chain) are split by a four-entry queue
// asynchronous active-low reset clears configuration registers to zero and empties the pipe
// configuration port is always ready
module stereo_homography_remap_unit import shrm_pkg::*; #(
	parameter int COORD_BITS = 12,
	parameter int MANTISSA_BITS = 20
) (
	input  logic       clk,
	input  logic       arst_n,
	shrm_cfg_if.sink   cfg,
	shrm_pix_if.sink   pix,
	shrm_res_if.source res
);

	// width of one signed row sum
	localparam int SW = MANTISSA_BITS + COORD_BITS + 2;

	// homography rows: left a, b, c then right a, b, c
	logic [NROWS-1:0][CFG_DATA_BITS-1:0]    rows_q;
	// image sizes: width low, height high
	logic [NUM_CAM-1:0][2*COORD_BITS-1:0]   sizes_q;

	logic                     push, pop;
	logic [NROWS-1:0][SW-1:0] push_sums, pop_sums;
	qstat_t                   qstat;

	// register writes, taken on every cfg transaction
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q  <= '0;
			sizes_q <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_LEFT_ROW_A:  rows_q[0] <= cfg.data;
				REG_LEFT_ROW_B:  rows_q[1] <= cfg.data;
				REG_LEFT_ROW_C:  rows_q[2] <= cfg.data;
				REG_RIGHT_ROW_A: rows_q[3] <= cfg.data;
				REG_RIGHT_ROW_B: rows_q[4] <= cfg.data;
				REG_RIGHT_ROW_C: rows_q[5] <= cfg.data;
				REG_LEFT_SIZE:   sizes_q[0] <= cfg.data[2*COORD_BITS-1:0];
				REG_RIGHT_SIZE:  sizes_q[1] <= cfg.data[2*COORD_BITS-1:0];
				default: ;
			endcase
		end
	end

	// front: multiplies (col, row, 1) by each row, yielding six exact sums
	shrm_front #(
		.COORD_BITS(COORD_BITS),
		.MANTISSA_BITS(MANTISSA_BITS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.pix(pix),
		.rows(rows_q),
		.qstat(qstat),
		.push(push),
		.sums(push_sums)
	);

	// decoupling queue, lets front and back stall independently
	shrm_queue #(
		.W(NROWS * SW)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_data(push_sums),
		.pop(pop),
		.pop_data(pop_sums),
		.qstat(qstat)
	);

	// back: rounding divide, bounds check, linear index, output register
	shrm_back #(
		.COORD_BITS(COORD_BITS),
		.MANTISSA_BITS(MANTISSA_BITS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.rows(rows_q),
		.sizes(sizes_q),
		.qstat(qstat),
		.sums(pop_sums),
		.pop(pop),
		.res(res)
	);

endmodule
